/* sv/ipv4_flow_header_parser_top_defines.svh */
// Assertion macros shared by the parser. They expand to nothing in synthesis.
`ifndef IPV4_FLOW_HEADER_PARSER_TOP_DEFINES_SVH
`define IPV4_FLOW_HEADER_PARSER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, off while reset is held.
`define IFHP_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is held.
`define IFHP_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`else

`define IFHP_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons, msg)
`define IFHP_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg)

`endif

`endif

/* sv/ifhp_pkg.sv */
package ifhp_pkg;

  localparam int unsigned CountW = 15;

  localparam logic [CountW-1:0] MaxFrameLen = 15'd16384;

  localparam logic [7:0]  EthHdrLen  = 8'd14;
  localparam logic [7:0]  VlanTagLen = 8'd4;
  localparam logic [7:0]  IpMinHdr   = 8'd20;
  localparam logic [7:0]  TcpMinHdr  = 8'd20;
  localparam logic [7:0]  SmallL4Hdr = 8'd8;
  localparam logic [15:0] VlanType   = 16'h8100;
  localparam logic [15:0] Ipv4Type   = 16'h0800;
  localparam logic [7:0]  LinkEther  = 8'd1;

  localparam logic [7:0] ProtoIcmp = 8'd1;
  localparam logic [7:0] ProtoTcp  = 8'd6;
  localparam logic [7:0] ProtoUdp  = 8'd17;

  // Everything a finished frame leaves behind for the result stage.
  typedef struct packed {
    logic              link_ok;
    logic [CountW-1:0] len;
    logic              has_vlan;
    logic [15:0]       ether_kind;
    logic [5:0]        ihl;
    logic [7:0]        proto;
    logic [31:0]       src;
    logic [31:0]       dst;
    logic [5:0]        l4hl;
    logic [15:0]       sport;
    logic [15:0]       dport;
  } summary_t;

endpackage

/* sv/ifhp_capture.sv */
module ifhp_capture (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  logic [7:0]          frame_byte,
  input  logic                last,
  input  logic                link_ok,
  input  logic                take,
  output logic                snap_valid,
  output ifhp_pkg::summary_t  snap
);

  logic [ifhp_pkg::CountW-1:0] count_r, count_nxt, count_sat;
  logic [15:0] kind_r, kind_nxt, kind_shift;
  logic        vlan_r, vlan_nxt;
  logic [5:0]  ihl_r, ihl_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [31:0] src_r, src_nxt;
  logic [31:0] dst_r, dst_nxt;
  logic [5:0]  l4hl_r, l4hl_nxt;
  logic [15:0] sport_r, sport_nxt;
  logic [15:0] dport_r, dport_nxt;
  logic        snap_v_r, snap_v_nxt;
  ifhp_pkg::summary_t snap_r;

  logic [7:0]  l3s, ip_end, l4_base, r3_full;
  logic [4:0]  r3;
  logic        in_ip, in_l4, is_port_proto;
  logic [ifhp_pkg::CountW-1:0] r4;

  assign kind_shift = {kind_r[7:0], frame_byte};
  assign l3s        = vlan_r ? (ifhp_pkg::EthHdrLen + ifhp_pkg::VlanTagLen)
                             : ifhp_pkg::EthHdrLen;
  assign ip_end     = l3s + ifhp_pkg::IpMinHdr;
  assign l4_base    = l3s + {2'b00, ihl_r};
  assign r3_full    = count_r[7:0] - l3s;
  assign r3         = r3_full[4:0];
  assign in_ip      = (count_r >= {7'd0, l3s}) && (count_r < {7'd0, ip_end});
  assign in_l4      = ({2'b00, ihl_r} >= ifhp_pkg::IpMinHdr) &&
                      (count_r >= {7'd0, ip_end}) && (count_r >= {7'd0, l4_base});
  assign r4         = count_r - {7'd0, l4_base};
  assign is_port_proto = (proto_r == ifhp_pkg::ProtoTcp) || (proto_r == ifhp_pkg::ProtoUdp);
  assign count_sat  = (count_r <= ifhp_pkg::MaxFrameLen) ? count_r + 15'd1 : count_r;

  always_comb begin
    kind_nxt   = kind_r;
    vlan_nxt   = vlan_r;
    ihl_nxt    = ihl_r;
    proto_nxt  = proto_r;
    src_nxt    = src_r;
    dst_nxt    = dst_r;
    l4hl_nxt   = l4hl_r;
    sport_nxt  = sport_r;
    dport_nxt  = dport_r;

    if ((count_r == 15'd12) || (count_r == 15'd13) ||
        (vlan_r && ((count_r == 15'd16) || (count_r == 15'd17)))) begin
      kind_nxt = kind_shift;
    end
    if ((count_r == 15'd13) && (kind_shift == ifhp_pkg::VlanType)) begin
      vlan_nxt = 1'b1;
    end

    if (in_ip) begin
      if (r3 == 5'd0) begin
        ihl_nxt = {frame_byte[3:0], 2'b00};
      end else if (r3 == 5'd9) begin
        proto_nxt = frame_byte;
      end else if ((r3 >= 5'd12) && (r3 < 5'd16)) begin
        src_nxt = {src_r[23:0], frame_byte};
      end else if (r3 >= 5'd16) begin
        dst_nxt = {dst_r[23:0], frame_byte};
      end
    end

    if (in_l4) begin
      if (is_port_proto) begin
        if (r4 < 15'd2) begin
          sport_nxt = {sport_r[7:0], frame_byte};
        end else if (r4 < 15'd4) begin
          dport_nxt = {dport_r[7:0], frame_byte};
        end
      end
      if ((proto_r == ifhp_pkg::ProtoTcp) && (r4 == 15'd12)) begin
        l4hl_nxt = {frame_byte[7:4], 2'b00};
      end
    end

    count_nxt = last ? '0 : count_sat;
  end

  assign snap_v_nxt = (acc && last) || (snap_v_r && !take);

  // Frame state: clear after every last byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      kind_r   <= '0;
      vlan_r   <= 1'b0;
      ihl_r    <= '0;
      proto_r  <= '0;
      src_r    <= '0;
      dst_r    <= '0;
      l4hl_r   <= '0;
      sport_r  <= '0;
      dport_r  <= '0;
      snap_v_r <= 1'b0;
    end else begin
      snap_v_r <= snap_v_nxt;
      if (acc) begin
        if (last) begin
          count_r  <= '0;
          kind_r   <= '0;
          vlan_r   <= 1'b0;
          ihl_r    <= '0;
          proto_r  <= '0;
          src_r    <= '0;
          dst_r    <= '0;
          l4hl_r   <= '0;
          sport_r  <= '0;
          dport_r  <= '0;
        end else begin
          count_r  <= count_nxt;
          kind_r   <= kind_nxt;
          vlan_r   <= vlan_nxt;
          ihl_r    <= ihl_nxt;
          proto_r  <= proto_nxt;
          src_r    <= src_nxt;
          dst_r    <= dst_nxt;
          l4hl_r   <= l4hl_nxt;
          sport_r  <= sport_nxt;
          dport_r  <= dport_nxt;
        end
      end
    end
  end

  // Snapshot of the finished frame.
  always_ff @(posedge clk) begin
    if (acc && last) begin
      snap_r.link_ok    <= link_ok;
      snap_r.len        <= count_r + 15'd1;
      snap_r.has_vlan   <= vlan_nxt;
      snap_r.ether_kind <= kind_nxt;
      snap_r.ihl        <= ihl_nxt;
      snap_r.proto      <= proto_nxt;
      snap_r.src        <= src_nxt;
      snap_r.dst        <= dst_nxt;
      snap_r.l4hl       <= l4hl_nxt;
      snap_r.sport      <= sport_nxt;
      snap_r.dport      <= dport_nxt;
    end
  end

  assign snap_valid = snap_v_r;
  assign snap       = snap_r;

endmodule

/* sv/ifhp_finish.sv */
module ifhp_finish (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                snap_valid,
  input  ifhp_pkg::summary_t  snap,
  input  logic                out_stall,
  output logic                ready,
  output logic                out_valid,
  output logic                out_status,
  output logic [31:0]         out_src_addr,
  output logic [31:0]         out_dst_addr,
  output logic [15:0]         out_src_port,
  output logic [15:0]         out_dst_port,
  output logic [7:0]          out_protocol,
  output logic [7:0]          out_payload_offset,
  output logic [14:0]         out_payload_length
);

  logic        valid_r, valid_nxt, load;
  logic        status_r;
  logic [31:0] src_r, dst_r;
  logic [15:0] sport_r, dport_r;
  logic [7:0]  proto_r, offset_r;
  logic [14:0] length_r;

  logic [7:0]  l3s, l3_end, l4hl, offset;
  logic        ports, fail;
  logic [14:0] length;

  assign l3s    = snap.has_vlan ? (ifhp_pkg::EthHdrLen + ifhp_pkg::VlanTagLen)
                                : ifhp_pkg::EthHdrLen;
  assign l3_end = l3s + {2'b00, snap.ihl};

  always_comb begin
    l4hl  = '0;
    ports = 1'b0;
    fail  = 1'b0;
    case (snap.proto)
      ifhp_pkg::ProtoTcp: begin
        l4hl  = {2'b00, snap.l4hl};
        ports = 1'b1;
        fail  = l4hl < ifhp_pkg::TcpMinHdr;
      end
      ifhp_pkg::ProtoUdp: begin
        l4hl  = ifhp_pkg::SmallL4Hdr;
        ports = 1'b1;
      end
      ifhp_pkg::ProtoIcmp: begin
        l4hl = ifhp_pkg::SmallL4Hdr;
      end
      default: begin
        l4hl = '0;
      end
    endcase
    offset = l3_end + l4hl;
    length = snap.len - {7'd0, offset};
    fail   = fail || !snap.link_ok ||
             (snap.len > ifhp_pkg::MaxFrameLen) ||
             (snap.len <= {7'd0, ifhp_pkg::EthHdrLen}) ||
             (snap.ether_kind != ifhp_pkg::Ipv4Type) ||
             (snap.len <= {7'd0, l3s}) ||
             ({2'b00, snap.ihl} < ifhp_pkg::IpMinHdr) ||
             (snap.len <= {7'd0, l3_end}) ||
             (snap.len <= {7'd0, offset});
  end

  assign ready     = !valid_r || !out_stall;
  assign load      = snap_valid && ready;
  assign valid_nxt = load || (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Zero every field but the status of a failed frame, and the ports of one with no ports.
  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= fail;
      src_r    <= fail ? '0 : snap.src;
      dst_r    <= fail ? '0 : snap.dst;
      sport_r  <= (fail || !ports) ? '0 : snap.sport;
      dport_r  <= (fail || !ports) ? '0 : snap.dport;
      proto_r  <= fail ? '0 : snap.proto;
      offset_r <= fail ? '0 : offset;
      length_r <= fail ? '0 : length;
    end
  end

  assign out_valid          = valid_r;
  assign out_status         = status_r;
  assign out_src_addr       = src_r;
  assign out_dst_addr       = dst_r;
  assign out_src_port       = sport_r;
  assign out_dst_port       = dport_r;
  assign out_protocol       = proto_r;
  assign out_payload_offset = offset_r;
  assign out_payload_length = length_r;

endmodule

/* sv/ipv4_flow_header_parser_top.sv */
// IPv4 flow header parser. Feed an Ethernet frame one byte per transaction on the in_
// channel, with in_last on its final byte; one result transaction on the out_ channel
// follows each frame and none for any other byte. A byte is taken every cycle unless
// in_stall is high: the per-byte field capture updates the frame state at the edge the
// byte is accepted, the finished frame is snapshotted at that same edge for its last
// byte, and the checks and payload arithmetic run between that snapshot register and
// the output register, where the result is held while out_stall is high. in_stall
// rises only while a snapshot waits behind an output transaction that is itself
// stalled. One optional 802.1Q tag is skipped; the frame fails unless EtherType is
// IPv4, cfg link type is Ethernet (reset value 1), the frame is no longer than 16384
// bytes, IHL and any TCP data offset give at least 20 bytes, and each header is
// strictly shorter than the bytes left for it. A failed result carries status 1 and
// all other fields zero. Write cfg only while no frame is in flight; it is sampled on
// each last byte.
`include "ipv4_flow_header_parser_top_defines.svh"

module ipv4_flow_header_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_frame_byte,
  input  logic        in_last,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_status,
  output logic [31:0] out_src_addr,
  output logic [31:0] out_dst_addr,
  output logic [15:0] out_src_port,
  output logic [15:0] out_dst_port,
  output logic [7:0]  out_protocol,
  output logic [7:0]  out_payload_offset,
  output logic [14:0] out_payload_length
);

  logic [7:0]         link_type_r;
  logic               in_acc;
  logic               snap_valid;
  logic               fin_ready;
  logic               snap_take;
  ifhp_pkg::summary_t snap;

  // Link type register: hold until written.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_type_r <= ifhp_pkg::LinkEther;
    end else if (cfg_wr_en) begin
      link_type_r <= cfg_wr_data;
    end
  end

  // Hold the input only when the snapshot cannot move on.
  assign in_stall  = snap_valid && !fin_ready;
  assign in_acc    = in_valid && !in_stall;
  assign snap_take = snap_valid && fin_ready;

  ifhp_capture u_capture (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (in_acc),
    .frame_byte (in_frame_byte),
    .last       (in_last),
    .link_ok    (link_type_r == ifhp_pkg::LinkEther),
    .take       (snap_take),
    .snap_valid (snap_valid),
    .snap       (snap)
  );

  ifhp_finish u_finish (
    .clk                (clk),
    .rst_n              (rst_n),
    .snap_valid         (snap_valid),
    .snap               (snap),
    .out_stall          (out_stall),
    .ready              (fin_ready),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_src_addr       (out_src_addr),
    .out_dst_addr       (out_dst_addr),
    .out_src_port       (out_src_port),
    .out_dst_port       (out_dst_port),
    .out_protocol       (out_protocol),
    .out_payload_offset (out_payload_offset),
    .out_payload_length (out_payload_length)
  );

  // A failed frame reports nothing but its status.
  `IFHP_ASSERT_IMPL(a_fail_zero, clk, rst_n, out_valid && out_status,
    (out_src_addr == 32'd0) && (out_dst_addr == 32'd0) && (out_protocol == 8'd0) &&
    (out_payload_offset == 8'd0) && (out_payload_length == 15'd0),
    "failed result carries nonzero fields")
  // A good frame has at least the Ethernet and minimal IPv4 headers before its payload.
  `IFHP_ASSERT_IMPL(a_ok_offset, clk, rst_n, out_valid && !out_status,
    (out_payload_offset >= 8'd34) && (out_payload_offset <= 8'd138) &&
    (out_payload_length != 15'd0),
    "good result with impossible offset or length")
  // Back-pressure reaches the input only behind a waiting result.
  `IFHP_ASSERT_IMPL(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall,
    "input stalled with no result waiting")
  // An accepted last byte always leaves a snapshot for the result stage on the next cycle.
  `IFHP_ASSERT_NEXT(a_last_snap, clk, rst_n, in_valid && !in_stall && in_last, snap_valid,
    "last byte left no snapshot")

endmodule
